// ===== hdl/hrp_pkg.sv =====
// Shared types, constants and helper functions of the HTTP request head parser.
package hrp_pkg;

  // Default width of the line and field byte counters.
  localparam int unsigned CNT_W_DEF = 12;

  // Configuration register widths and reset values.
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [12:0] RST_MAX_LINE    = 13'd2048;
  localparam logic [7:0]  RST_MAX_METHOD  = 8'd32;
  localparam logic [11:0] RST_MAX_URL     = 12'd1024;
  localparam logic [7:0]  RST_MAX_VERSION = 8'd32;
  localparam logic [7:0]  RST_MAX_HEADERS = 8'd32;

  // Characters the parser looks for.
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SP      = 8'h20;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  typedef enum logic [2:0] {
    CFG_MAX_LINE    = 3'd0,
    CFG_MAX_METHOD  = 3'd1,
    CFG_MAX_URL     = 3'd2,
    CFG_MAX_VERSION = 3'd3,
    CFG_MAX_HEADERS = 3'd4
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URL     = 3'd1,
    PH_VERSION = 3'd2,
    PH_NAME    = 3'd3,
    PH_VALUE   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    K_METHOD  = 3'd0,
    K_URL     = 3'd1,
    K_VERSION = 3'd2,
    K_NAME    = 3'd3,
    K_VALUE   = 3'd4,
    K_END     = 3'd5,
    K_DONE    = 3'd6,
    K_ERROR   = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_LINE_LONG   = 4'd1,
    ERR_BARE_CR     = 4'd2,
    ERR_METHOD_LONG = 4'd3,
    ERR_URL_LONG    = 4'd4,
    ERR_VER_LONG    = 4'd5,
    ERR_HEADERS     = 4'd6,
    ERR_REQ_LINE    = 4'd7,
    ERR_HDR_LINE    = 4'd8,
    ERR_ESCAPE      = 4'd9
  } err_t;

  // Ended-field numbers carried in the value of a field end result.
  localparam logic [7:0] FLD_METHOD  = 8'd0;
  localparam logic [7:0] FLD_URL     = 8'd1;
  localparam logic [7:0] FLD_VERSION = 8'd2;
  localparam logic [7:0] FLD_NAME    = 8'd3;
  localparam logic [7:0] FLD_VALUE   = 8'd4;

  // Method classes reported at head done.
  localparam logic [1:0] MC_OTHER = 2'd0;
  localparam logic [1:0] MC_GET   = 2'd1;
  localparam logic [1:0] MC_POST  = 2'd2;

  typedef struct packed {
    logic [12:0] max_line;
    logic [7:0]  max_method;
    logic [11:0] max_url;
    logic [7:0]  max_version;
    logic [7:0]  max_headers;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  value;
    err_t        error_code;
    logic [1:0]  method_class;
    logic [7:0]  header_total;
  } res_t;

  // Byte held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } in_stage_t;

  // Result offered by the parser core for the output register.
  typedef struct packed {
    logic emit;
    res_t res;
  } core_out_t;

  function automatic logic [7:0] to_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5A) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [7:0] get_char(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = 8'h67;
      2'd1:    r = 8'h65;
      2'd2:    r = 8'h74;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] post_char(input logic [1:0] i);
    logic [7:0] r;
    case (i)
      2'd0:    r = 8'h70;
      2'd1:    r = 8'h6F;
      2'd2:    r = 8'h73;
      default: r = 8'h74;
    endcase
    return r;
  endfunction

  // Hex digit value; bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = 5'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = 5'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = 5'(b - 8'h37);
    end
    return r;
  endfunction

endpackage

// ===== hdl/hrp_in_if.sv =====
// Request channel that carries one raw byte of the request stream.
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// ===== hdl/hrp_out_if.sv =====
// Request channel that carries one parser result.
interface hrp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;
  logic [3:0] error_code;
  logic [1:0] method_class;
  logic [7:0] header_total;

  modport source (output valid, output kind, output value, output error_code,
                  output method_class, output header_total, input ready);
  modport sink (input valid, input kind, input value, input error_code,
                input method_class, input header_total, output ready);
endinterface

// ===== hdl/http_request_head_parser.sv =====
// A byte goes from the input register through the parser core into the output register.
// Throughput: one byte per clock; the input register feeds the parser state update and the
// result register in one pass, so only a stalled output register holds the input back.
// CR bytes, an escape's '%' and first hex digit and bytes skipped after a colon give no result.
// Reset (rst_n low, synchronous) empties both registers, restarts the parser at the
// request line and loads the limits 2048, 32, 1024, 32, 32.
module http_request_head_parser
  import hrp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CNT_W_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  hrp_in_if.sink                 in_if,
  hrp_out_if.source              out_if,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t      cfg;
  in_stage_t stage;
  core_out_t co;
  logic      out_free;
  logic      advance;

  // The held byte is parsed when the output register can take its result.
  assign advance = stage.valid && out_free;

  hrp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hrp_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .advance (advance),
    .stage   (stage)
  );

  hrp_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .b     (stage.data),
    .cfg   (cfg),
    .co    (co)
  );

  hrp_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .co       (co),
    .out_free (out_free),
    .out_if   (out_if)
  );

`ifndef ASSERT_OFF
  // An error result always carries a code, and no other result does.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> ((out_if.kind == K_ERROR) == (out_if.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  // A method class is only reported with head done.
  a_class: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.kind != K_DONE) |-> (out_if.method_class == MC_OTHER))
    else $error("method class outside head done");

  // A new result only appears after the parser advanced on a byte.
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_if.valid) |-> $past(advance))
    else $error("result appeared without a parsed byte");

  // The input side stalls only while the input register is full.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> stage.valid)
    else $error("input stalled with empty input register");
`endif

endmodule

// ===== hdl/hrp_cfg_regs.sv =====
// Configuration registers of the parser, written through a plain write port.
module hrp_cfg_regs
  import hrp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output cfg_t                   cfg
);

  cfg_t cfg_r;

  // Decode the register index; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_line    <= RST_MAX_LINE;
      cfg_r.max_method  <= RST_MAX_METHOD;
      cfg_r.max_url     <= RST_MAX_URL;
      cfg_r.max_version <= RST_MAX_VERSION;
      cfg_r.max_headers <= RST_MAX_HEADERS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_LINE:    cfg_r.max_line    <= cfg_wdata;
        CFG_MAX_METHOD:  cfg_r.max_method  <= cfg_wdata[7:0];
        CFG_MAX_URL:     cfg_r.max_url     <= cfg_wdata[11:0];
        CFG_MAX_VERSION: cfg_r.max_version <= cfg_wdata[7:0];
        CFG_MAX_HEADERS: cfg_r.max_headers <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/hrp_in_stage.sv =====
// Input register that holds one byte until the parser core takes it.
module hrp_in_stage
  import hrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  hrp_in_if.sink     in_if,
  input  logic       advance,
  output in_stage_t  stage
);

  logic       vld_r;
  logic [7:0] byte_r;

  // The register can take a byte when empty or when its byte moves on.
  assign in_if.ready = !vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      vld_r <= 1'b1;
    end else if (advance) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      byte_r <= in_if.in_byte;
    end
  end

  assign stage.valid = vld_r;
  assign stage.data  = byte_r;

endmodule

// ===== hdl/hrp_core.sv =====
// Parser state and the per-byte decode that updates it and forms the result.
module hrp_core
  import hrp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = CNT_W_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] b,
  input  cfg_t       cfg,
  output core_out_t  co
);

  localparam int unsigned CMPW = (COUNT_WIDTH + 1 > 13) ? COUNT_WIDTH + 1 : 13;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  phase_t                 phase_r, phase_nxt;
  logic [COUNT_WIDTH-1:0] line_r, line_nxt;
  logic [COUNT_WIDTH-1:0] field_r, field_nxt;
  logic [7:0]             hdr_r, hdr_nxt;
  logic                   cr_r, cr_nxt;
  logic [1:0]             esc_r, esc_nxt;
  logic [3:0]             hi_r, hi_nxt;
  logic [1:0]             skip_r, skip_nxt;
  logic                   getm_r, getm_nxt;
  logic                   postm_r, postm_nxt;

  logic       restart;
  err_t       err;
  logic       line_full;
  logic       field_full;
  logic [CMPW-1:0] field_lim;
  logic [4:0] hx;
  logic [7:0] lb;

  assign lb = to_lower(b);
  assign hx = hex_val(b);

  // Line length check: the new byte must keep the line below the limit.
  assign line_full = (line_r == CNT_MAX) ||
                     ((CMPW'(line_r) + CMPW'(1)) >= CMPW'(cfg.max_line));

  // Token length limit of the current request line field.
  always_comb begin
    case (phase_r)
      PH_METHOD: field_lim = CMPW'(cfg.max_method);
      PH_URL:    field_lim = CMPW'(cfg.max_url);
      default:   field_lim = CMPW'(cfg.max_version);
    endcase
  end
  assign field_full = (field_r == CNT_MAX) || (CMPW'(field_r) == field_lim);

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_nxt = phase_r;
    line_nxt  = line_r;
    field_nxt = field_r;
    hdr_nxt   = hdr_r;
    cr_nxt    = cr_r;
    esc_nxt   = esc_r;
    hi_nxt    = hi_r;
    skip_nxt  = skip_r;
    getm_nxt  = getm_r;
    postm_nxt = postm_r;
    restart   = 1'b0;
    err       = ERR_NONE;
    co        = '0;

    if (step) begin
      if (cr_r) begin
        cr_nxt = 1'b0;
        if (b != CH_LF) begin
          err = ERR_BARE_CR;
        end else begin
          // End of line.
          unique case (phase_r)
            PH_VERSION: begin
              phase_nxt    = PH_NAME;
              line_nxt     = '0;
              field_nxt    = '0;
              co.emit      = 1'b1;
              co.res.kind  = K_END;
              co.res.value = FLD_VERSION;
            end
            PH_NAME: begin
              if (line_r == '0) begin
                co.emit             = 1'b1;
                co.res.kind         = K_DONE;
                co.res.method_class = getm_r ? MC_GET : (postm_r ? MC_POST : MC_OTHER);
                co.res.header_total = hdr_r;
                restart             = 1'b1;
              end else begin
                err = ERR_HDR_LINE;
              end
            end
            PH_VALUE: begin
              if (skip_r >= 2'd2) begin
                err = ERR_HDR_LINE;
              end else begin
                phase_nxt    = PH_NAME;
                skip_nxt     = '0;
                line_nxt     = '0;
                co.emit      = 1'b1;
                co.res.kind  = K_END;
                co.res.value = FLD_VALUE;
              end
            end
            default: err = ERR_REQ_LINE;
          endcase
        end
      end else if (b == CH_CR) begin
        cr_nxt = 1'b1;
      end else if (line_full) begin
        err = ERR_LINE_LONG;
      end else begin
        line_nxt = line_r + 1'b1;
        unique case (phase_r)
          PH_METHOD: begin
            if (b == CH_SP) begin
              if (field_r != COUNT_WIDTH'(3)) getm_nxt = 1'b0;
              if (field_r != COUNT_WIDTH'(4)) postm_nxt = 1'b0;
              phase_nxt    = PH_URL;
              field_nxt    = '0;
              co.emit      = 1'b1;
              co.res.kind  = K_END;
              co.res.value = FLD_METHOD;
            end else if (field_full) begin
              err = ERR_METHOD_LONG;
            end else begin
              if (field_r >= COUNT_WIDTH'(3) || lb != get_char(field_r[1:0])) begin
                getm_nxt = 1'b0;
              end
              if (field_r >= COUNT_WIDTH'(4) || lb != post_char(field_r[1:0])) begin
                postm_nxt = 1'b0;
              end
              field_nxt    = field_r + 1'b1;
              co.emit      = 1'b1;
              co.res.kind  = K_METHOD;
              co.res.value = b;
            end
          end
          PH_URL: begin
            if (b == CH_SP) begin
              if (esc_r != 2'd0) begin
                err = ERR_ESCAPE;
              end else begin
                phase_nxt    = PH_VERSION;
                field_nxt    = '0;
                co.emit      = 1'b1;
                co.res.kind  = K_END;
                co.res.value = FLD_URL;
              end
            end else if (field_full) begin
              err = ERR_URL_LONG;
            end else begin
              field_nxt = field_r + 1'b1;
              // Percent escape: two hex digits follow the percent sign.
              if (esc_r == 2'd1) begin
                if (hx[4]) begin
                  err = ERR_ESCAPE;
                end else begin
                  hi_nxt  = hx[3:0];
                  esc_nxt = 2'd2;
                end
              end else if (esc_r == 2'd2) begin
                if (hx[4]) begin
                  err = ERR_ESCAPE;
                end else begin
                  esc_nxt      = 2'd0;
                  co.emit      = 1'b1;
                  co.res.kind  = K_URL;
                  co.res.value = {hi_r, hx[3:0]};
                end
              end else if (b == CH_PERCENT) begin
                esc_nxt = 2'd1;
              end else begin
                co.emit      = 1'b1;
                co.res.kind  = K_URL;
                co.res.value = b;
              end
            end
          end
          PH_VERSION: begin
            if (field_full) begin
              err = ERR_VER_LONG;
            end else begin
              field_nxt    = field_r + 1'b1;
              co.emit      = 1'b1;
              co.res.kind  = K_VERSION;
              co.res.value = b;
            end
          end
          PH_NAME: begin
            if (line_r == '0 && hdr_r >= cfg.max_headers) begin
              err = ERR_HEADERS;
            end else begin
              if (line_r == '0) hdr_nxt = hdr_r + 8'd1;
              co.emit = 1'b1;
              if (b == CH_COLON) begin
                phase_nxt    = PH_VALUE;
                skip_nxt     = 2'd2;
                co.res.kind  = K_END;
                co.res.value = FLD_NAME;
              end else begin
                co.res.kind  = K_NAME;
                co.res.value = b;
              end
            end
          end
          PH_VALUE: begin
            if (skip_r != 2'd0) begin
              skip_nxt = skip_r - 2'd1;
            end else begin
              co.emit      = 1'b1;
              co.res.kind  = K_VALUE;
              co.res.value = b;
            end
          end
          default: err = ERR_REQ_LINE;
        endcase
      end
    end

    // Any error reports itself and restarts the parser.
    if (err != ERR_NONE) begin
      co                = '0;
      co.emit           = 1'b1;
      co.res.kind       = K_ERROR;
      co.res.error_code = err;
      restart           = 1'b1;
    end

    if (restart) begin
      phase_nxt = PH_METHOD;
      line_nxt  = '0;
      field_nxt = '0;
      hdr_nxt   = '0;
      cr_nxt    = 1'b0;
      esc_nxt   = '0;
      hi_nxt    = '0;
      skip_nxt  = '0;
      getm_nxt  = 1'b1;
      postm_nxt = 1'b1;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD;
      line_r  <= '0;
      field_r <= '0;
      hdr_r   <= '0;
      cr_r    <= 1'b0;
      esc_r   <= '0;
      hi_r    <= '0;
      skip_r  <= '0;
      getm_r  <= 1'b1;
      postm_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      line_r  <= line_nxt;
      field_r <= field_nxt;
      hdr_r   <= hdr_nxt;
      cr_r    <= cr_nxt;
      esc_r   <= esc_nxt;
      hi_r    <= hi_nxt;
      skip_r  <= skip_nxt;
      getm_r  <= getm_nxt;
      postm_r <= postm_nxt;
    end
  end

endmodule

// ===== hdl/hrp_out_stage.sv =====
// Output register that holds one result until the sink takes it.
module hrp_out_stage
  import hrp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  core_out_t  co,
  output logic       out_free,
  hrp_out_if.source  out_if
);

  logic vld_r;
  res_t res_r;

  // The register is free when empty or when its result is taken now.
  assign out_free = !vld_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (out_free) begin
      vld_r <= advance && co.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && co.emit) begin
      res_r <= co.res;
    end
  end

  assign out_if.valid        = vld_r;
  assign out_if.kind         = res_r.kind;
  assign out_if.value        = res_r.value;
  assign out_if.error_code   = res_r.error_code;
  assign out_if.method_class = res_r.method_class;
  assign out_if.header_total = res_r.header_total;

endmodule
